FILE: rtl/p192fr_pkg.sv
// Shared types and constants of the P-192 fast reduction block.
package p192fr_pkg;

   localparam int unsigned WORD_W    = 64;
   localparam int unsigned MOD_W     = 3 * WORD_W;
   localparam int unsigned SUM_W     = MOD_W + 3;
   localparam int unsigned IN_CNT_W  = 3;
   localparam int unsigned OUT_CNT_W = 2;
   localparam int unsigned BIT_CNT_W = 8;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [IN_CNT_W-1:0]  LAST_IN_IDX  = IN_CNT_W'(5);
   localparam logic [OUT_CNT_W-1:0] LAST_OUT_IDX = OUT_CNT_W'(2);
   localparam logic [BIT_CNT_W-1:0] TOP_BIT_IDX  = BIT_CNT_W'(SUM_W - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_MID  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_HIGH = CSR_IDX_W'(2);

   localparam logic [WORD_W-1:0] MODULUS_LOW_RST  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [WORD_W-1:0] MODULUS_MID_RST  = 64'hFFFF_FFFF_FFFF_FFFE;
   localparam logic [WORD_W-1:0] MODULUS_HIGH_RST = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      ST_LOAD   = 3'b001,
      ST_REDUCE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   typedef struct packed {
      logic                 acc_load;
      logic                 acc_first;
      logic [IN_CNT_W-1:0]  word_idx;
      logic                 rem_clear;
      logic                 rem_step;
      logic                 rem_bypass;
      logic [OUT_CNT_W-1:0] out_sel;
   } cmd_type;

   typedef struct packed {
      logic mod_zero;
   } status_type;

endpackage

FILE: rtl/p192fr_ctrl.sv
// Controller state machine: word loading, remainder steps and residue transfers.
module p192fr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_residue_last,
   input  p192fr_pkg::status_type status,
   output p192fr_pkg::cmd_type   cmd
);

   p192fr_pkg::state_type                       state_ff, state_in;
   logic [p192fr_pkg::IN_CNT_W-1:0]             word_cnt_ff, word_cnt_in;
   logic [p192fr_pkg::BIT_CNT_W-1:0]            bit_cnt_ff, bit_cnt_in;
   logic [p192fr_pkg::OUT_CNT_W-1:0]            out_cnt_ff, out_cnt_in;
   logic                                        req_xfer;
   logic                                        rsp_xfer;

   assign req_stall        = (state_ff != p192fr_pkg::ST_LOAD);
   assign rsp_valid        = (state_ff == p192fr_pkg::ST_EMIT);
   assign rsp_residue_last = (out_cnt_ff == p192fr_pkg::LAST_OUT_IDX);
   assign req_xfer         = req_valid && !req_stall;
   assign rsp_xfer         = rsp_valid && !rsp_stall;

   always_comb begin
      state_in        = state_ff;
      word_cnt_in     = word_cnt_ff;
      bit_cnt_in      = bit_cnt_ff;
      out_cnt_in      = out_cnt_ff;
      cmd.acc_load    = 1'b0;
      cmd.acc_first   = (word_cnt_ff == '0);
      cmd.word_idx    = word_cnt_ff;
      cmd.rem_clear   = 1'b0;
      cmd.rem_step    = 1'b0;
      cmd.rem_bypass  = 1'b0;
      cmd.out_sel     = out_cnt_ff;
      unique case (state_ff)
         p192fr_pkg::ST_LOAD: begin
            if (req_xfer) begin
               cmd.acc_load = 1'b1;
               if (word_cnt_ff == p192fr_pkg::LAST_IN_IDX) begin
                  word_cnt_in   = '0;
                  bit_cnt_in    = p192fr_pkg::TOP_BIT_IDX;
                  cmd.rem_clear = 1'b1;
                  state_in      = p192fr_pkg::ST_REDUCE;
               end else begin
                  word_cnt_in = word_cnt_ff + 1'b1;
               end
            end
         end
         p192fr_pkg::ST_REDUCE: begin
            if (status.mod_zero) begin
               cmd.rem_bypass = 1'b1;
               state_in       = p192fr_pkg::ST_EMIT;
            end else begin
               cmd.rem_step = 1'b1;
               bit_cnt_in   = bit_cnt_ff - 1'b1;
               if (bit_cnt_ff == '0) begin
                  state_in = p192fr_pkg::ST_EMIT;
               end
            end
         end
         p192fr_pkg::ST_EMIT: begin
            if (rsp_xfer) begin
               if (out_cnt_ff == p192fr_pkg::LAST_OUT_IDX) begin
                  out_cnt_in = '0;
                  state_in   = p192fr_pkg::ST_LOAD;
               end else begin
                  out_cnt_in = out_cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = p192fr_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= p192fr_pkg::ST_LOAD;
         word_cnt_ff <= '0;
         bit_cnt_ff  <= '0;
         out_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         word_cnt_ff <= word_cnt_in;
         bit_cnt_ff  <= bit_cnt_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

endmodule

FILE: rtl/p192fr_dp.sv
// Datapath: modulus registers, reduction-sum accumulator and bit-serial remainder unit.
module p192fr_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [p192fr_pkg::WORD_W-1:0]        req_product_word,
   input  logic                                 csr_write_enable,
   input  logic [p192fr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [p192fr_pkg::WORD_W-1:0]        csr_write_data,
   input  p192fr_pkg::cmd_type                  cmd,
   output p192fr_pkg::status_type               status,
   output logic [p192fr_pkg::WORD_W-1:0]        rsp_residue_word
);

   localparam int unsigned W = p192fr_pkg::WORD_W;
   localparam int unsigned M = p192fr_pkg::MOD_W;
   localparam int unsigned S = p192fr_pkg::SUM_W;

   logic [W-1:0]   mod_low_ff, mod_mid_ff, mod_high_ff;
   logic [S-1:0]   sum_ff, sum_in;
   logic [M-1:0]   rem_ff, rem_in;
   logic [M-1:0]   modulus;
   logic [W-1:0]   term_lo, term_mid, term_hi;
   logic [S-1:0]   term;
   logic [S-1:0]   acc_base;
   logic [M:0]     shifted;
   logic [M+1:0]   diff;

   assign modulus         = {mod_high_ff, mod_mid_ff, mod_low_ff};
   assign status.mod_zero = (modulus == '0);

   // Each product word adds its share of the four fast-reduction terms.
   always_comb begin
      term_lo  = '0;
      term_mid = '0;
      term_hi  = '0;
      case (cmd.word_idx)
         3'd0: term_lo = req_product_word;
         3'd1: term_mid = req_product_word;
         3'd2: term_hi = req_product_word;
         3'd3: begin
            term_lo  = req_product_word;
            term_mid = req_product_word;
         end
         3'd4: begin
            term_mid = req_product_word;
            term_hi  = req_product_word;
         end
         3'd5: begin
            term_lo  = req_product_word;
            term_mid = req_product_word;
            term_hi  = req_product_word;
         end
         default: begin
            term_lo = '0;
         end
      endcase
      term     = {3'b000, term_hi, term_mid, term_lo};
      acc_base = cmd.acc_first ? '0 : sum_ff;
   end

   always_comb begin
      sum_in = sum_ff;
      if (cmd.acc_load) begin
         sum_in = acc_base + term;
      end else if (cmd.rem_step) begin
         sum_in = {sum_ff[S-2:0], 1'b0};
      end
   end

   // One restoring-division step per cycle, most significant sum bit first.
   always_comb begin
      shifted = {rem_ff, sum_ff[S-1]};
      diff    = {1'b0, shifted} - {2'b00, modulus};
      rem_in  = rem_ff;
      if (cmd.rem_clear) begin
         rem_in = '0;
      end else if (cmd.rem_bypass) begin
         rem_in = sum_ff[M-1:0];
      end else if (cmd.rem_step) begin
         rem_in = diff[M+1] ? shifted[M-1:0] : diff[M-1:0];
      end
   end

   always_comb begin
      case (cmd.out_sel)
         2'd0:    rsp_residue_word = rem_ff[W-1:0];
         2'd1:    rsp_residue_word = rem_ff[2*W-1:W];
         default: rsp_residue_word = rem_ff[M-1:2*W];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_low_ff  <= p192fr_pkg::MODULUS_LOW_RST;
         mod_mid_ff  <= p192fr_pkg::MODULUS_MID_RST;
         mod_high_ff <= p192fr_pkg::MODULUS_HIGH_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            p192fr_pkg::CSR_MODULUS_LOW:  mod_low_ff  <= csr_write_data;
            p192fr_pkg::CSR_MODULUS_MID:  mod_mid_ff  <= csr_write_data;
            p192fr_pkg::CSR_MODULUS_HIGH: mod_high_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      rem_ff <= rem_in;
   end

endmodule

FILE: rtl/p192_fast_reduction.sv
// Top level of the P-192 fast modular reduction block.
// The request channel takes a 384-bit product as six 64-bit words, least significant
// first, one transfer per cycle while req_stall is low. Each word is folded into the
// fast-reduction sum as it arrives, so the sum is complete at the sixth transfer.
// The sum is then reduced modulo the programmed modulus by a bit-serial remainder
// unit, one sum bit per cycle over all 195 sum bits; when the modulus is zero the
// steps are skipped and the low 192 bits of the sum pass through unchanged.
// The residue leaves on the response channel as three 64-bit words, low word first,
// with rsp_residue_last on the third. The first word is offered once the reduction
// or the pass-through is done. The block handles one product at a time: req_stall
// stays high from the sixth word until the third residue word has been transferred.
// While rsp_stall is high the current residue word and flag hold.
// The csr port writes the modulus words (index 0 low, 1 middle, 2 high); the user
// must use it only while the block is idle, as the block does not enforce this.
// Synchronous reset returns the controller to loading the first product word and
// sets the modulus to the P-192 prime.
module p192_fast_reduction (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [p192fr_pkg::WORD_W-1:0]       req_product_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [p192fr_pkg::WORD_W-1:0]       rsp_residue_word,
   output logic                                rsp_residue_last,
   input  logic                                csr_write_enable,
   input  logic [p192fr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [p192fr_pkg::WORD_W-1:0]       csr_write_data
);

   p192fr_pkg::cmd_type    cmd;
   p192fr_pkg::status_type status;

   p192fr_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_residue_last (rsp_residue_last),
      .status           (status),
      .cmd              (cmd)
   );

   p192fr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_product_word (req_product_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_residue_word (rsp_residue_word)
   );

endmodule

FILE: rtl/p192fr_checker.sv
// Port-level assertions for the P-192 fast reduction block and their bind.
module p192fr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [p192fr_pkg::WORD_W-1:0]      rsp_residue_word,
   input logic                               rsp_residue_last
);

   // A stalled residue word holds until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_residue_word)
         && $stable(rsp_residue_last))
      else $error("stalled residue word changed");

   // No product word is taken while a residue is being delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken during residue delivery");

   // The last residue word ends the burst.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_residue_last |=> !rsp_valid && !req_stall)
      else $error("residue burst did not end after last word");

   // Reset leaves no residue pending and the request side open.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("residue pending after reset");

endmodule

bind p192_fast_reduction p192fr_checker u_p192fr_checker (.*);
